// ----- design/plg_pkg.sv -----
// Shared types and constants for the polygon point and edge test.
package plg_pkg;

    localparam int DEF_MAX_VERTS  = 64;
    localparam int DEF_COORD_BITS = 16;
    localparam int IN_W           = 16;
    localparam int AREA_W         = 40;

    typedef enum logic [1:0] {
        MODE_CLEAR   = 2'd0,
        MODE_APPEND  = 2'd1,
        MODE_POINT   = 2'd2,
        MODE_SEGMENT = 2'd3
    } t_mode;

    // sign code: {negative, nonzero}
    typedef logic [1:0] t_sgn;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_edge_tag;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        t_sgn s1;
        t_sgn s2;
        t_sgn s3;
        t_sgn s4;
    } t_edge_out;

endpackage

// ----- design/plg_cell.sv -----
// One vertex cell of the rotating vertex chain.
module plg_cell
    import plg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic                         i_load,
    input  logic signed [COORD_BITS-1:0] i_shift_x,
    input  logic signed [COORD_BITS-1:0] i_shift_y,
    input  logic signed [COORD_BITS-1:0] i_load_x,
    input  logic signed [COORD_BITS-1:0] i_load_y,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_x <= i_load_x;
            r_y <= i_load_y;
        end else if (i_shift) begin
            r_x <= i_shift_x;
            r_y <= i_shift_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

// ----- design/plg_edge.sv -----
// Three-stage orientation unit: differences, products, cross signs.
module plg_edge
    import plg_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int D_W = COORD_BITS + 1,
    localparam int P_W = 2 * COORD_BITS + 2,
    localparam int X_W = 2 * COORD_BITS + 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_edge_tag                    i_tag,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    input  logic signed [COORD_BITS-1:0] i_dx,
    input  logic signed [COORD_BITS-1:0] i_dy,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by,
    output t_edge_out                    o_res,
    output logic signed [X_W-1:0]        o_x1
);

    t_edge_tag r1_tag, r2_tag;
    logic signed [D_W-1:0] r1_d [12];
    logic signed [P_W-1:0] r2_p [8];
    t_edge_out r3_res;
    logic signed [X_W-1:0] r3_x1;
    logic signed [X_W-1:0] w_x [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_res <= '0;
        end else begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_res.valid <= r2_tag.valid;
            r3_res.first <= r2_tag.first;
            r3_res.last  <= r2_tag.last;
            r3_res.s1 <= {w_x[0] < 0, w_x[0] != '0};
            r3_res.s2 <= {w_x[1] < 0, w_x[1] != '0};
            r3_res.s3 <= {w_x[2] < 0, w_x[2] != '0};
            r3_res.s4 <= {w_x[3] < 0, w_x[3] != '0};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_d[0]  <= D_W'(i_dx) - D_W'(i_cx);
        r1_d[1]  <= D_W'(i_dy) - D_W'(i_cy);
        r1_d[2]  <= D_W'(i_ax) - D_W'(i_cx);
        r1_d[3]  <= D_W'(i_ay) - D_W'(i_cy);
        r1_d[4]  <= D_W'(i_bx) - D_W'(i_cx);
        r1_d[5]  <= D_W'(i_by) - D_W'(i_cy);
        r1_d[6]  <= D_W'(i_bx) - D_W'(i_ax);
        r1_d[7]  <= D_W'(i_by) - D_W'(i_ay);
        r1_d[8]  <= D_W'(i_cx) - D_W'(i_ax);
        r1_d[9]  <= D_W'(i_cy) - D_W'(i_ay);
        r1_d[10] <= D_W'(i_dx) - D_W'(i_ax);
        r1_d[11] <= D_W'(i_dy) - D_W'(i_ay);
        r2_p[0] <= P_W'(r1_d[0]) * P_W'(r1_d[3]);
        r2_p[1] <= P_W'(r1_d[1]) * P_W'(r1_d[2]);
        r2_p[2] <= P_W'(r1_d[0]) * P_W'(r1_d[5]);
        r2_p[3] <= P_W'(r1_d[1]) * P_W'(r1_d[4]);
        r2_p[4] <= P_W'(r1_d[6]) * P_W'(r1_d[9]);
        r2_p[5] <= P_W'(r1_d[7]) * P_W'(r1_d[8]);
        r2_p[6] <= P_W'(r1_d[6]) * P_W'(r1_d[11]);
        r2_p[7] <= P_W'(r1_d[7]) * P_W'(r1_d[10]);
        r3_x1 <= w_x[0];
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_x[k] = X_W'(r2_p[2*k]) - X_W'(r2_p[2*k+1]);
        end
    end

    assign o_res = r3_res;
    assign o_x1  = r3_x1;

endmodule

// ----- design/polygon_point_and_edge_test.sv -----
// Top level: vertex cell chain, orientation unit and item sequencer.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-----------------------------------------------
//  input   | i_valid | o_ready | i_mode i_ax i_ay i_bx i_by
//  result  | o_valid | i_ready | o_inside_res o_crosses o_vertex_count
//          |         |         | o_double_area o_status
//
// Point and segment queries rotate the vertex chain once, one edge per cycle
// into the three-stage orientation unit. An append that adds an area term
// also passes its edge through the unit before its result is ready.
// Synchronous active-low reset clears count, area and control; vertices hold
// no reset. A finished result waits in the output register while the next
// beat is taken; the sequencer stalls only when that register is still full.
module polygon_point_and_edge_test
    import plg_pkg::*;
#(
    parameter int MAX_VERTS  = DEF_MAX_VERTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    localparam int CNT_W = $clog2(MAX_VERTS + 1),
    localparam int X_W   = 2 * COORD_BITS + 3,
    localparam int S_W   = ((X_W > AREA_W) ? X_W : AREA_W) + 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_mode,
    input  logic [IN_W-1:0]   i_ax,
    input  logic [IN_W-1:0]   i_ay,
    input  logic [IN_W-1:0]   i_bx,
    input  logic [IN_W-1:0]   i_by,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_inside_res,
    output logic              o_crosses,
    output logic [CNT_W-1:0]  o_vertex_count,
    output logic [AREA_W-1:0] o_double_area,
    output logic              o_status
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_AREA = 5'b00010,
        S_ROT  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTS);
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    logic signed [COORD_BITS-1:0] w_ax, w_ay, w_bx, w_by;

    generate
        if (COORD_BITS <= IN_W) begin : g_narrow
            assign w_ax = i_ax[COORD_BITS-1:0];
            assign w_ay = i_ay[COORD_BITS-1:0];
            assign w_bx = i_bx[COORD_BITS-1:0];
            assign w_by = i_by[COORD_BITS-1:0];
        end else begin : g_wide
            assign w_ax = {{(COORD_BITS-IN_W){1'b0}}, i_ax};
            assign w_ay = {{(COORD_BITS-IN_W){1'b0}}, i_ay};
            assign w_bx = {{(COORD_BITS-IN_W){1'b0}}, i_bx};
            assign w_by = {{(COORD_BITS-IN_W){1'b0}}, i_by};
        end
    endgenerate

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic signed [COORD_BITS-1:0] r_ax, r_ay, r_bx, r_by;
    logic signed [COORD_BITS-1:0] r_v0x, r_v0y, r_vlx, r_vly, r_prx, r_pry;
    logic signed [COORD_BITS-1:0] n_v0x, n_v0y, n_vlx, n_vly;
    logic [CNT_W-1:0]  r_count, n_count, r_t, n_t;
    logic [AREA_W-1:0] r_area, n_area;
    logic r_inside, n_inside, r_cross, n_cross, r_status, n_status;
    logic r_done, n_done;
    t_sgn r_first, n_first;
    logic r_o_valid, n_o_valid;
    logic r_o_inside, r_o_cross, r_o_status;
    logic [CNT_W-1:0]  r_o_count;
    logic [AREA_W-1:0] r_o_area;

    logic w_acc, w_shift, w_load;
    t_edge_tag w_tag;
    logic signed [COORD_BITS-1:0] w_cx, w_cy, w_dx, w_dy;
    t_edge_out w_eo;
    logic signed [X_W-1:0] w_x1;
    logic [X_W-1:0] w_abs;
    logic [S_W-1:0] w_sum;

    logic signed [COORD_BITS-1:0] w_cell_x [MAX_VERTS];
    logic signed [COORD_BITS-1:0] w_cell_y [MAX_VERTS];

    // cell k shifts from k+1, the head wraps to the tail
    generate
        for (genvar k = 0; k < MAX_VERTS; k++) begin : g_cell
            plg_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                .i_clk     (i_clk),
                .i_shift   (w_shift),
                .i_load    (w_load && (r_count == CNT_W'(k))),
                .i_shift_x (w_cell_x[(k + 1) % MAX_VERTS]),
                .i_shift_y (w_cell_y[(k + 1) % MAX_VERTS]),
                .i_load_x  (r_ax),
                .i_load_y  (r_ay),
                .o_x       (w_cell_x[k]),
                .o_y       (w_cell_y[k])
            );
        end
    endgenerate

    plg_edge #(.COORD_BITS(COORD_BITS)) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_cx    (w_cx),
        .i_cy    (w_cy),
        .i_dx    (w_dx),
        .i_dy    (w_dy),
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_bx    (r_bx),
        .i_by    (r_by),
        .o_res   (w_eo),
        .o_x1    (w_x1)
    );

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = i_valid && o_ready;
    assign w_shift = (r_state == S_ROT) && (r_t != MAX_CNT);
    assign w_load  = (r_state == S_AREA);
    assign w_abs   = (w_x1 < 0) ? X_W'(-w_x1) : X_W'(w_x1);
    assign w_sum   = S_W'(r_area) + S_W'(w_abs);

    // feed one edge: the area term in append, else the edge ending at the head (the first vertex closes the ring)
    always_comb begin
        w_tag = '0;
        w_cx  = r_prx;
        w_cy  = r_pry;
        w_dx  = (r_t == r_count) ? r_v0x : w_cell_x[0];
        w_dy  = (r_t == r_count) ? r_v0y : w_cell_y[0];
        if (r_state == S_AREA) begin
            w_cx = r_v0x;
            w_cy = r_v0y;
            w_dx = r_vlx;
            w_dy = r_vly;
            w_tag.valid = (r_count >= CNT_W'(2));
            w_tag.first = 1'b1;
            w_tag.last  = 1'b1;
        end else if (r_state == S_ROT) begin
            w_tag.valid = (r_t != '0) && (r_t <= r_count);
            w_tag.first = (r_t == CNT_W'(1));
            w_tag.last  = (r_t == r_count);
        end
    end

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_count   = r_count;
        n_area    = r_area;
        n_t       = r_t;
        n_inside  = r_inside;
        n_cross   = r_cross;
        n_status  = r_status;
        n_done    = r_done;
        n_first   = r_first;
        n_v0x     = r_v0x;
        n_v0y     = r_v0y;
        n_vlx     = r_vlx;
        n_vly     = r_vly;
        n_o_valid = r_o_valid && !i_ready;

        // fold edge results as they leave the orientation unit
        if (w_eo.valid) begin
            unique case (r_mode)
                MODE_POINT: begin
                    if (w_eo.first) begin
                        n_first = w_eo.s1;
                    end else if (w_eo.s1 != r_first) begin
                        n_inside = 1'b0;
                    end
                end
                MODE_SEGMENT: begin
                    if ((w_eo.s1 != w_eo.s2) && (w_eo.s3 != w_eo.s4)) begin
                        n_cross = 1'b1;
                    end
                end
                MODE_APPEND: begin
                    n_area = (w_sum > S_W'(AREA_MAX)) ? AREA_MAX : w_sum[AREA_W-1:0];
                end
                default: begin
                end
            endcase
            if (w_eo.last) begin
                n_done = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_mode   = t_mode'(i_mode);
                    n_inside = 1'b0;
                    n_cross  = 1'b0;
                    n_status = 1'b0;
                    n_done   = 1'b0;
                    n_t      = '0;
                    unique case (t_mode'(i_mode))
                        MODE_CLEAR: begin
                            n_count = '0;
                            n_area  = '0;
                            n_state = S_OUT;
                        end
                        MODE_APPEND: begin
                            if (r_count == MAX_CNT) begin
                                n_status = 1'b1;
                                n_state  = S_OUT;
                            end else begin
                                n_state = S_AREA;
                            end
                        end
                        MODE_POINT: begin
                            if (r_count < CNT_W'(2)) begin
                                n_state = S_OUT;
                            end else begin
                                n_inside = 1'b1;
                                n_state  = S_ROT;
                            end
                        end
                        MODE_SEGMENT: begin
                            n_state = (r_count == '0) ? S_OUT : S_ROT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_AREA: begin
                if (r_count == '0) begin
                    n_v0x = r_ax;
                    n_v0y = r_ay;
                end
                n_vlx   = r_ax;
                n_vly   = r_ay;
                n_count = r_count + CNT_W'(1);
                n_state = (r_count >= CNT_W'(2)) ? S_WAIT : S_OUT;
            end
            S_ROT: begin
                if (r_t == MAX_CNT) begin
                    n_state = S_WAIT;
                end else begin
                    n_t = r_t + CNT_W'(1);
                end
            end
            S_WAIT: begin
                if (r_done || (w_eo.valid && w_eo.last)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_CLEAR;
            r_count   <= '0;
            r_area    <= '0;
            r_t       <= '0;
            r_inside  <= 1'b0;
            r_cross   <= 1'b0;
            r_status  <= 1'b0;
            r_done    <= 1'b0;
            r_first   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_area    <= n_area;
            r_t       <= n_t;
            r_inside  <= n_inside;
            r_cross   <= n_cross;
            r_status  <= n_status;
            r_done    <= n_done;
            r_first   <= n_first;
            r_o_valid <= n_o_valid;
        end
    end

    // payload: operands, anchor vertices, result slot
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ax <= w_ax;
            r_ay <= w_ay;
            r_bx <= w_bx;
            r_by <= w_by;
        end
        r_v0x <= n_v0x;
        r_v0y <= n_v0y;
        r_vlx <= n_vlx;
        r_vly <= n_vly;
        r_prx <= w_cell_x[0];
        r_pry <= w_cell_y[0];
        if ((r_state == S_OUT) && (!r_o_valid || i_ready)) begin
            r_o_inside <= r_inside;
            r_o_cross  <= r_cross;
            r_o_status <= r_status;
            r_o_count  <= r_count;
            r_o_area   <= r_area;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_inside_res   = r_o_inside;
    assign o_crosses      = r_o_cross;
    assign o_status       = r_o_status;
    assign o_vertex_count = r_o_count;
    assign o_double_area  = r_o_area;

endmodule
